// File: rtl/sol_pkg.sv
`default_nettype none
package sol_pkg;

  typedef enum logic [1:0] {
    MODE_PUSH   = 2'd0,
    MODE_POP    = 2'd1,
    MODE_REMOVE = 2'd2,
    MODE_FIND   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_FULL      = 2'd1,
    STATUS_EMPTY     = 2'd2,
    STATUS_NOT_FOUND = 2'd3
  } status_e;

  // control broadcast to every cell of the chain
  typedef struct packed {
    logic load;    // capture the per-cell match flag
    logic push;    // open a slot at the first match and insert
    logic delete;  // close the slot at the first match
  } sol_cmd_t;

endpackage
`default_nettype wire

// File: rtl/sol_in_if.sv
`default_nettype none
interface sol_in_if #(
  parameter int NODE_BITS = 16,
  parameter int COST_BITS = 24
);
  logic                 valid;
  logic                 ready;
  logic [1:0]           mode;
  logic [NODE_BITS-1:0] node_id;
  logic [COST_BITS-1:0] cost_so_far;
  logic [COST_BITS-1:0] estimated_cost;

  modport source (output valid, mode, node_id, cost_so_far, estimated_cost, input ready);
  modport sink   (input valid, mode, node_id, cost_so_far, estimated_cost, output ready);
endinterface
`default_nettype wire

// File: rtl/sol_out_if.sv
`default_nettype none
interface sol_out_if #(
  parameter int NODE_BITS = 16,
  parameter int COST_BITS = 24,
  parameter int CNT_BITS  = 7
);
  logic                 valid;
  logic                 ready;
  logic [1:0]           status;
  logic [NODE_BITS-1:0] node_out;
  logic [COST_BITS-1:0] cost_so_far_out;
  logic [COST_BITS-1:0] estimated_out;
  logic [CNT_BITS-1:0]  count;

  modport source (output valid, status, node_out, cost_so_far_out, estimated_out, count,
                  input ready);
  modport sink   (input valid, status, node_out, cost_so_far_out, estimated_out, count,
                  output ready);
endinterface
`default_nettype wire

// File: rtl/sol_cell.sv
`default_nettype none
module sol_cell
  import sol_pkg::*;
#(
  parameter int  NODE_BITS = 16,
  parameter int  COST_BITS = 24,
  parameter bit  FIRST     = 1'b0
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire sol_cmd_t             cmd_i,
  input  wire mode_e                mode_i,
  input  wire logic                 order_key_i,
  input  wire logic [NODE_BITS-1:0] cmp_node_i,
  input  wire logic [COST_BITS-1:0] cmp_key_i,
  // record to insert
  input  wire logic [NODE_BITS-1:0] new_node_i,
  input  wire logic [COST_BITS-1:0] new_cost_i,
  input  wire logic [COST_BITS-1:0] new_est_i,
  // left neighbour (towards the head)
  input  wire logic                 left_valid_i,
  input  wire logic [NODE_BITS-1:0] left_node_i,
  input  wire logic [COST_BITS-1:0] left_cost_i,
  input  wire logic [COST_BITS-1:0] left_est_i,
  // right neighbour (towards the tail)
  input  wire logic                 right_valid_i,
  input  wire logic [NODE_BITS-1:0] right_node_i,
  input  wire logic [COST_BITS-1:0] right_cost_i,
  input  wire logic [COST_BITS-1:0] right_est_i,
  // running flag: some cell nearer the head matched
  input  wire logic                 ahead_i,
  output logic                      ahead_o,
  // running selection of the first matching record
  input  wire logic [NODE_BITS-1:0] sel_node_i,
  input  wire logic [COST_BITS-1:0] sel_cost_i,
  input  wire logic [COST_BITS-1:0] sel_est_i,
  output logic [NODE_BITS-1:0]      sel_node_o,
  output logic [COST_BITS-1:0]      sel_cost_o,
  output logic [COST_BITS-1:0]      sel_est_o,
  output logic                      valid_o,
  output logic [NODE_BITS-1:0]      node_o,
  output logic [COST_BITS-1:0]      cost_o,
  output logic [COST_BITS-1:0]      est_o
);

  logic                 valid_q, valid_d;
  logic                 hit_q, hit_d;
  logic [NODE_BITS-1:0] node_q, node_d;
  logic [COST_BITS-1:0] cost_q, cost_d;
  logic [COST_BITS-1:0] est_q, est_d;
  logic [COST_BITS-1:0] own_key;
  logic                 first;

  assign own_key = order_key_i ? est_q : cost_q;
  assign first   = hit_q & ~ahead_i;

  always_comb begin
    hit_d = hit_q;
    if (cmd_i.load) begin
      case (mode_i)
        MODE_PUSH:   hit_d = ~valid_q | (own_key >= cmp_key_i);
        MODE_POP:    hit_d = FIRST;
        MODE_REMOVE: hit_d = valid_q & (node_q == cmp_node_i);
        MODE_FIND:   hit_d = valid_q & (node_q == cmp_node_i);
        default:     hit_d = 1'b0;
      endcase
    end
  end

  always_comb begin
    valid_d = valid_q;
    node_d  = node_q;
    cost_d  = cost_q;
    est_d   = est_q;
    if (cmd_i.push) begin
      if (ahead_i) begin
        valid_d = left_valid_i;
        node_d  = left_node_i;
        cost_d  = left_cost_i;
        est_d   = left_est_i;
      end else if (hit_q) begin
        valid_d = 1'b1;
        node_d  = new_node_i;
        cost_d  = new_cost_i;
        est_d   = new_est_i;
      end
    end else if (cmd_i.delete) begin
      if (ahead_i | hit_q) begin
        valid_d = right_valid_i;
        node_d  = right_node_i;
        cost_d  = right_cost_i;
        est_d   = right_est_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      hit_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      hit_q   <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    node_q <= node_d;
    cost_q <= cost_d;
    est_q  <= est_d;
  end

  assign ahead_o    = ahead_i | hit_q;
  assign sel_node_o = sel_node_i | (first ? node_q : '0);
  assign sel_cost_o = sel_cost_i | (first ? cost_q : '0);
  assign sel_est_o  = sel_est_i  | (first ? est_q  : '0);
  assign valid_o    = valid_q;
  assign node_o     = node_q;
  assign cost_o     = cost_q;
  assign est_o      = est_q;

endmodule
`default_nettype wire

// File: rtl/sorted_open_list_queue.sv
// sorted open list for path search: records of node id, cost so far and
// estimated total cost, held in ascending key order in a row of cells
// in_i   : command beats (push, pop smallest, remove by node, find by node)
// out_o  : one result beat per command, with status and the count held after
// cfg_we_i / cfg_data_i : order key select, 0 cost so far, 1 estimated cost
// each command runs in steps: the accept edge latches a match flag in every
// cell, then the edge that leaves ST_EXEC shifts the chain and loads the result
// register; the first-match flag ripples along the row of cells in ST_EXEC
// in_i.ready is high while no command is in flight, so the next beat can
// follow right after the previous one finishes
// if out_o stalls, the command in flight waits in ST_EXEC until the
// result register frees; a finished result waits in that register
// reset empties the queue (valid bits cleared at once, no sweep) and sets
// the order key to estimated total cost
`default_nettype none
module sorted_open_list_queue
  import sol_pkg::*;
#(
  parameter int QUEUE_DEPTH = 64,
  parameter int NODE_BITS   = 16,
  parameter int COST_BITS   = 24
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic cfg_we_i,
  input  wire logic cfg_data_i,
  sol_in_if.sink    in_i,
  sol_out_if.source out_o
);

  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e               state_q;
  logic                 order_key_q;
  mode_e                mode_q;
  logic [NODE_BITS-1:0] node_q;
  logic [COST_BITS-1:0] cost_q;
  logic [COST_BITS-1:0] est_q;
  logic [CNT_BITS-1:0]  count_q;

  logic                 out_valid_q;
  status_e              status_q;
  logic [NODE_BITS-1:0] res_node_q;
  logic [COST_BITS-1:0] res_cost_q;
  logic [COST_BITS-1:0] res_est_q;

  logic                 accept;
  logic                 exec;
  mode_e                in_mode;
  logic [COST_BITS-1:0] cmp_key;
  sol_cmd_t             cmd;

  logic                 cell_valid [QUEUE_DEPTH];
  logic [NODE_BITS-1:0] cell_node  [QUEUE_DEPTH];
  logic [COST_BITS-1:0] cell_cost  [QUEUE_DEPTH];
  logic [COST_BITS-1:0] cell_est   [QUEUE_DEPTH];
  logic                 ahead      [QUEUE_DEPTH+1];
  logic [NODE_BITS-1:0] sel_node   [QUEUE_DEPTH+1];
  logic [COST_BITS-1:0] sel_cost   [QUEUE_DEPTH+1];
  logic [COST_BITS-1:0] sel_est    [QUEUE_DEPTH+1];

  logic                 full;
  logic                 empty;
  logic                 found;
  status_e              status_d;
  logic                 do_push;
  logic                 do_delete;
  logic                 give_rec;

  assign in_mode = mode_e'(in_i.mode);
  assign in_i.ready = (state_q == ST_IDLE);
  assign accept  = in_i.valid & in_i.ready;
  assign exec    = (state_q == ST_EXEC) & (~out_valid_q | out_o.ready);
  assign cmp_key = order_key_q ? in_i.estimated_cost : in_i.cost_so_far;

  assign full  = cell_valid[QUEUE_DEPTH-1];
  assign empty = ~cell_valid[0];
  assign found = ahead[QUEUE_DEPTH];

  always_comb begin
    status_d  = STATUS_OK;
    do_push   = 1'b0;
    do_delete = 1'b0;
    give_rec  = 1'b0;
    case (mode_q)
      MODE_PUSH: begin
        if (full) status_d = STATUS_FULL;
        else      do_push  = 1'b1;
      end
      MODE_POP: begin
        if (empty) status_d = STATUS_EMPTY;
        else begin
          do_delete = 1'b1;
          give_rec  = 1'b1;
        end
      end
      MODE_REMOVE: begin
        if (!found) status_d  = STATUS_NOT_FOUND;
        else        do_delete = 1'b1;
      end
      MODE_FIND: begin
        if (!found) status_d = STATUS_NOT_FOUND;
        else        give_rec = 1'b1;
      end
      default: status_d = STATUS_OK;
    endcase
  end

  assign cmd.load   = accept;
  assign cmd.push   = exec & do_push;
  assign cmd.delete = exec & do_delete;

  assign ahead[0]    = 1'b0;
  assign sel_node[0] = '0;
  assign sel_cost[0] = '0;
  assign sel_est[0]  = '0;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic                 lv, rv;
    logic [NODE_BITS-1:0] ln, rn;
    logic [COST_BITS-1:0] lc, rc, le, re;

    if (i == 0) begin : g_head
      assign lv = 1'b0;
      assign ln = '0;
      assign lc = '0;
      assign le = '0;
    end else begin : g_left
      assign lv = cell_valid[i-1];
      assign ln = cell_node[i-1];
      assign lc = cell_cost[i-1];
      assign le = cell_est[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign rv = 1'b0;
      assign rn = '0;
      assign rc = '0;
      assign re = '0;
    end else begin : g_right
      assign rv = cell_valid[i+1];
      assign rn = cell_node[i+1];
      assign rc = cell_cost[i+1];
      assign re = cell_est[i+1];
    end

    sol_cell #(
      .NODE_BITS (NODE_BITS),
      .COST_BITS (COST_BITS),
      .FIRST     (i == 0)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .cmd_i         (cmd),
      .mode_i        (in_mode),
      .order_key_i   (order_key_q),
      .cmp_node_i    (in_i.node_id),
      .cmp_key_i     (cmp_key),
      .new_node_i    (node_q),
      .new_cost_i    (cost_q),
      .new_est_i     (est_q),
      .left_valid_i  (lv),
      .left_node_i   (ln),
      .left_cost_i   (lc),
      .left_est_i    (le),
      .right_valid_i (rv),
      .right_node_i  (rn),
      .right_cost_i  (rc),
      .right_est_i   (re),
      .ahead_i       (ahead[i]),
      .ahead_o       (ahead[i+1]),
      .sel_node_i    (sel_node[i]),
      .sel_cost_i    (sel_cost[i]),
      .sel_est_i     (sel_est[i]),
      .sel_node_o    (sel_node[i+1]),
      .sel_cost_o    (sel_cost[i+1]),
      .sel_est_o     (sel_est[i+1]),
      .valid_o       (cell_valid[i]),
      .node_o        (cell_node[i]),
      .cost_o        (cell_cost[i]),
      .est_o         (cell_est[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      order_key_q <= 1'b1;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      status_q    <= STATUS_OK;
      mode_q      <= MODE_PUSH;
    end else begin
      if (cfg_we_i) order_key_q <= cfg_data_i;
      if (out_o.ready) out_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            mode_q  <= in_mode;
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (exec) begin
            out_valid_q <= 1'b1;
            status_q    <= status_d;
            if (do_push)   count_q <= count_q + CNT_BITS'(1);
            if (do_delete) count_q <= count_q - CNT_BITS'(1);
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      node_q <= in_i.node_id;
      cost_q <= in_i.cost_so_far;
      est_q  <= in_i.estimated_cost;
    end
    if (exec) begin
      res_node_q <= give_rec ? sel_node[QUEUE_DEPTH] : '0;
      res_cost_q <= give_rec ? sel_cost[QUEUE_DEPTH] : '0;
      res_est_q  <= give_rec ? sel_est[QUEUE_DEPTH]  : '0;
    end
  end

  // count after the beat: the update lands at the same edge as the result
  assign out_o.valid           = out_valid_q;
  assign out_o.status          = status_q;
  assign out_o.node_out        = res_node_q;
  assign out_o.cost_so_far_out = res_cost_q;
  assign out_o.estimated_out   = res_est_q;
  assign out_o.count           = count_q;

endmodule
`default_nettype wire

// File: tb/sorted_open_list_queue_tb.sv
`default_nettype none
module sorted_open_list_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sol_pkg::*;

  localparam int DEPTH        = 64;
  localparam int LIMIT_CYCLES = 400_000;
  localparam int HOLD_AT      = 250;
  localparam int HOLD_LEN     = 300;

  typedef struct packed {
    logic [15:0] node;
    logic [23:0] cost;
    logic [23:0] est;
  } rec_t;

  typedef struct {
    mode_e       mode;
    logic [15:0] node;
    logic [23:0] cost;
    logic [23:0] est;
  } cmd_t;

  typedef struct {
    status_e     status;
    logic [15:0] node;
    logic [23:0] cost;
    logic [23:0] est;
    logic [6:0]  count;
  } res_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we;
  logic cfg_data;

  sol_in_if  #(.NODE_BITS(16), .COST_BITS(24)) in_bus ();
  sol_out_if #(.NODE_BITS(16), .COST_BITS(24), .CNT_BITS(7)) out_bus ();

  sorted_open_list_queue #(
    .QUEUE_DEPTH(DEPTH),
    .NODE_BITS  (16),
    .COST_BITS  (24)
  ) uut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we),
    .cfg_data_i(cfg_data),
    .in_i      (in_bus),
    .out_o     (out_bus)
  );

  cmd_t pending_cmds[$];
  res_t expected_results[$];
  rec_t open_list[$];
  logic key_sel;
  logic idle_on;
  int   mismatches;
  cmd_t on_bus;
  res_t head;
  int   src_gap;
  int   sink_gap;
  int   hold_left;
  bit   hold_done;
  int   beats_out;
  int   cycles;

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [23:0] rand_cost();
    case ($urandom_range(0, 3))
      0: return 24'($urandom_range(0, 7));
      1: return ($urandom_range(0, 1) != 0) ? 24'hFFFFFF : 24'h0;
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [23:0] key_of(rec_t r);
    return key_sel ? r.est : r.cost;
  endfunction

  // mirror of the sorted list, updated once per accepted command
  function automatic res_t predict_result(cmd_t c);
    res_t r;
    rec_t rec;
    int   at;
    int   pos;
    int   i;
    r.status = STATUS_OK;
    r.node   = '0;
    r.cost   = '0;
    r.est    = '0;
    rec.node = c.node;
    rec.cost = c.cost;
    rec.est  = c.est;
    case (c.mode)
      MODE_PUSH: begin
        if (open_list.size() >= DEPTH) begin
          r.status = STATUS_FULL;
        end else begin
          at = 0;
          while (at < open_list.size() && key_of(open_list[at]) < key_of(rec)) at++;
          open_list.insert(at, rec);
        end
      end
      MODE_POP: begin
        if (open_list.size() == 0) begin
          r.status = STATUS_EMPTY;
        end else begin
          r.node = open_list[0].node;
          r.cost = open_list[0].cost;
          r.est  = open_list[0].est;
          open_list.delete(0);
        end
      end
      default: begin
        pos = -1;
        for (i = 0; i < open_list.size(); i++) begin
          if (pos < 0 && open_list[i].node == c.node) pos = i;
        end
        if (pos < 0) begin
          r.status = STATUS_NOT_FOUND;
        end else if (c.mode == MODE_REMOVE) begin
          open_list.delete(pos);
        end else begin
          r.node = open_list[pos].node;
          r.cost = open_list[pos].cost;
          r.est  = open_list[pos].est;
        end
      end
    endcase
    r.count = 7'(open_list.size());
    return r;
  endfunction

  task automatic report(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic add_cmd(input mode_e m, input logic [15:0] n, input logic [23:0] c,
                         input logic [23:0] e);
    cmd_t x;
    x.mode = m;
    x.node = n;
    x.cost = c;
    x.est  = e;
    pending_cmds.push_back(x);
  endtask

  task automatic add_random(input int n, input int push_pct);
    int          k;
    int          r;
    mode_e       m;
    logic [15:0] nd;
    for (k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < push_pct) m = MODE_PUSH;
      else begin
        case ($urandom_range(0, 2))
          0: m = MODE_POP;
          1: m = MODE_REMOVE;
          default: m = MODE_FIND;
        endcase
      end
      // a small pool of nodes keeps remove and find hitting held records
      nd = ($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, 15)) : 16'($urandom);
      add_cmd(m, nd, rand_cost(), rand_cost());
    end
  endtask

  task automatic wait_drained();
    while (pending_cmds.size() != 0 || in_bus.valid || expected_results.size() != 0)
      @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_order_key(input logic v);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    key_sel  = v;
    @(negedge clk_i);
  endtask

  // driver: one beat per pending command, random gaps between beats while idle_on is set
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_bus.valid <= 1'b0;
      src_gap      = 0;
    end else begin
      if (in_bus.valid && in_bus.ready) expected_results.push_back(predict_result(on_bus));
      if (!in_bus.valid || in_bus.ready) begin
        if (src_gap > 0) begin
          src_gap--;
          in_bus.valid <= 1'b0;
        end else if (pending_cmds.size() != 0) begin
          on_bus = pending_cmds[0];
          pending_cmds.delete(0);
          in_bus.valid          <= 1'b1;
          in_bus.mode           <= on_bus.mode;
          in_bus.node_id        <= on_bus.node;
          in_bus.cost_so_far    <= on_bus.cost;
          in_bus.estimated_cost <= on_bus.est;
          src_gap = idle_on ? pick_gap() : 0;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // receiver ready, with one long hold-off so the block backs up
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
      sink_gap  = 0;
      hold_left = 0;
      hold_done = 1'b0;
      beats_out = 0;
    end else begin
      if (out_bus.valid && out_bus.ready) beats_out++;
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else if (!hold_done && beats_out >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_LEN;
        out_bus.ready <= 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
        sink_gap = idle_on ? pick_gap() : 0;
      end
    end
  end

  // monitor: every result beat against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      if (expected_results.size() == 0) begin
        report("result beat with nothing expected");
      end else begin
        head = expected_results[0];
        expected_results.delete(0);
        if (out_bus.status !== head.status)
          report($sformatf("status got %0d want %0d", out_bus.status, head.status));
        if (out_bus.node_out !== head.node)
          report($sformatf("node_out got %h want %h", out_bus.node_out, head.node));
        if (out_bus.cost_so_far_out !== head.cost)
          report($sformatf("cost_so_far_out got %h want %h", out_bus.cost_so_far_out,
                           head.cost));
        if (out_bus.estimated_out !== head.est)
          report($sformatf("estimated_out got %h want %h", out_bus.estimated_out, head.est));
        if (out_bus.count !== head.count)
          report($sformatf("count got %0d want %0d", out_bus.count, head.count));
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    cycles                = 0;
    mismatches            = 0;
    key_sel               = 1'b1;
    idle_on               = 1'b1;
    rst_ni                = 1'b0;
    cfg_we                = 1'b0;
    cfg_data              = 1'b0;
    in_bus.valid          = 1'b0;
    in_bus.mode           = MODE_PUSH;
    in_bus.node_id        = '0;
    in_bus.cost_so_far    = '0;
    in_bus.estimated_cost = '0;
    out_bus.ready         = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    write_order_key(1'b1);
    // empty queue, extremes, equal keys, duplicate nodes
    add_cmd(MODE_POP,    16'h0000, 24'h000000, 24'h000000);
    add_cmd(MODE_FIND,   16'h0000, 24'hFFFFFF, 24'hFFFFFF);
    add_cmd(MODE_REMOVE, 16'hFFFF, 24'h000000, 24'h000000);
    add_cmd(MODE_PUSH,   16'h0000, 24'h000000, 24'hFFFFFF);
    add_cmd(MODE_PUSH,   16'hFFFF, 24'hFFFFFF, 24'h000000);
    add_cmd(MODE_PUSH,   16'h1234, 24'h000005, 24'h000000);
    add_cmd(MODE_PUSH,   16'h0007, 24'h000005, 24'hFFFFFF);
    add_cmd(MODE_FIND,   16'hFFFF, 24'h000000, 24'h000000);
    add_cmd(MODE_FIND,   16'h0000, 24'h000000, 24'h000000);
    add_cmd(MODE_FIND,   16'h9999, 24'h000000, 24'h000000);
    add_cmd(MODE_REMOVE, 16'h1234, 24'h000000, 24'h000000);
    add_cmd(MODE_REMOVE, 16'h1234, 24'h000000, 24'h000000);
    add_cmd(MODE_PUSH,   16'hAAAA, 24'h555555, 24'hAAAAAA);
    add_cmd(MODE_POP,    16'h0000, 24'h000000, 24'h000000);
    add_cmd(MODE_POP,    16'hFFFF, 24'hFFFFFF, 24'hFFFFFF);
    add_cmd(MODE_POP,    16'h0000, 24'h000000, 24'h000000);
    add_cmd(MODE_POP,    16'h0000, 24'h000000, 24'h000000);
    add_cmd(MODE_POP,    16'h0000, 24'h000000, 24'h000000);
    add_cmd(MODE_PUSH,   16'h5555, 24'hAAAAAA, 24'h555555);
    add_cmd(MODE_PUSH,   16'h5555, 24'h000001, 24'h000001);
    add_cmd(MODE_FIND,   16'h5555, 24'h000000, 24'h000000);
    add_cmd(MODE_REMOVE, 16'h5555, 24'h000000, 24'h000000);
    add_cmd(MODE_POP,    16'h0000, 24'h000000, 24'h000000);
    add_cmd(MODE_POP,    16'h0000, 24'h000000, 24'h000000);
    wait_drained();

    // key flips while records are held; push-heavy phases run into full,
    // pop-heavy ones drain to empty
    for (int ph = 0; ph < 6; ph++) begin
      write_order_key(ph[0] ? 1'b1 : 1'b0);
      idle_on = (ph % 3 != 2);
      case (ph)
        0: add_random(150, 85);
        1: add_random(130, 50);
        2: add_random(130, 20);
        3: add_random(130, 90);
        4: add_random(130, 45);
        default: add_random(130, 15);
      endcase
      wait_drained();
    end

    repeat (10) @(negedge clk_i);
    if (expected_results.size() != 0) report("results still expected at end of run");
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
`default_nettype wire
